>>> rtl/tpgt_pkg.sv
// Shared types, state codes and arithmetic constants of the touch point gesture tracker.
`default_nettype none

package tpgt_pkg;

    localparam int COORD_W = 12;
    localparam int IDX_W   = 2;
    localparam int STATE_W = 3;
    localparam int TIME_W  = 16;
    localparam int VEL_W   = 16;
    localparam int THR_W   = 12;
    localparam int MAX_POINTS = 4;

    localparam int SQ_W      = 2 * COORD_W + 1;
    localparam int TV_W      = 22;
    localparam int VEL_SHIFT = 4;

    localparam logic [THR_W-1:0]          THR_RESET    = THR_W'(20);
    localparam logic [TIME_W-1:0]         ELAPSED_STEP = TIME_W'(10);
    localparam logic signed [TV_W-1:0]    VEL_GAIN     = TV_W'(15);
    localparam logic signed [TV_W-1:0]    STEP_GAIN    = TV_W'(100);
    localparam logic signed [TV_W-1:0]    VEL_MAX      = TV_W'(32767);
    localparam logic signed [TV_W-1:0]    VEL_MIN      = -TV_W'(32768);

    localparam logic [STATE_W-1:0] ST_NONE   = 3'd0;
    localparam logic [STATE_W-1:0] ST_DOWN   = 3'd1;
    localparam logic [STATE_W-1:0] ST_HOLD   = 3'd2;
    localparam logic [STATE_W-1:0] ST_MSTART = 3'd3;
    localparam logic [STATE_W-1:0] ST_MOVE   = 3'd4;
    localparam logic [STATE_W-1:0] ST_UP     = 3'd5;
    localparam logic [STATE_W-1:0] ST_MULTI  = 3'd6;

    typedef struct packed {
        logic [IDX_W-1:0]   point_index;
        logic               touch_present;
        logic [COORD_W-1:0] sample_x;
        logic [COORD_W-1:0] sample_y;
        logic               end_of_tick;
    } t_in_beat;

    typedef struct packed {
        logic [IDX_W-1:0]        out_index;
        logic [STATE_W-1:0]      gesture_state;
        logic [COORD_W-1:0]      pos_x;
        logic [COORD_W-1:0]      pos_y;
        logic [TIME_W-1:0]       held_ms;
        logic signed [VEL_W-1:0] speed_x;
        logic signed [VEL_W-1:0] speed_y;
        logic                    last_record;
    } t_out_beat;

    typedef struct packed {
        logic accept;
        logic load;
        logic sq_a;
        logic sq_b;
        logic sum;
        logic update;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic point_live;
        logic out_free;
    } t_dp_status;

    function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [TV_W-1:0] t);
        logic signed [TV_W-1:0] q;
        q = t >>> VEL_SHIFT;
        if (q > VEL_MAX) begin
            sat_vel = VEL_MAX[VEL_W-1:0];
        end else if (q < VEL_MIN) begin
            sat_vel = VEL_MIN[VEL_W-1:0];
        end else begin
            sat_vel = q[VEL_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/tpgt_datapath.sv
// Datapath: per-point state, sample latches, distance and velocity arithmetic, output register.
`default_nettype none

module tpgt_datapath #(
    parameter int NPTS = 4,
    parameter int CW   = 12,
    parameter int IW   = 2
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tpgt_pkg::t_dp_cmd             i_cmd,
    input  wire logic [IW-1:0]                 i_ptr,
    input  wire tpgt_pkg::t_in_beat            i_in_data,
    input  wire logic                          i_cfg_we,
    input  wire logic [tpgt_pkg::THR_W-1:0]    i_cfg_data,
    input  wire logic                          i_out_stall,
    output tpgt_pkg::t_dp_status               o_status,
    output logic                               o_out_valid,
    output tpgt_pkg::t_out_beat                o_out_data
);

    localparam logic [tpgt_pkg::IDX_W:0] NPTS_L = (tpgt_pkg::IDX_W + 1)'(NPTS);

    logic [tpgt_pkg::STATE_W-1:0]      r_pstate  [NPTS];
    logic [CW-1:0]                     r_track_x [NPTS];
    logic [CW-1:0]                     r_track_y [NPTS];
    logic [CW-1:0]                     r_anc_x   [NPTS];
    logic [CW-1:0]                     r_anc_y   [NPTS];
    logic [tpgt_pkg::TIME_W-1:0]       r_elapsed [NPTS];
    logic signed [tpgt_pkg::VEL_W-1:0] r_vel_x   [NPTS];
    logic signed [tpgt_pkg::VEL_W-1:0] r_vel_y   [NPTS];
    logic                              r_lat_p   [NPTS];
    logic [CW-1:0]                     r_lat_x   [NPTS];
    logic [CW-1:0]                     r_lat_y   [NPTS];

    logic [tpgt_pkg::THR_W-1:0]        r_thr;
    logic signed [CW:0]                r_dx, r_dy, r_vdx, r_vdy;
    logic [2*CW-1:0]                   r_sq_a, r_sq_b;
    logic signed [tpgt_pkg::TV_W-1:0]  r_tv_x, r_tv_y;
    logic [tpgt_pkg::SQ_W-1:0]         r_d2;
    logic [2*tpgt_pkg::THR_W-1:0]      r_th2;
    logic                              r_any, r_multi;
    logic [IW-1:0]                     r_last;
    logic                              r_out_valid;
    tpgt_pkg::t_out_beat               r_out;

    logic                              n_out_valid;
    logic [tpgt_pkg::STATE_W-1:0]      n_state;
    logic [CW-1:0]                     n_track_x, n_track_y, n_anc_x, n_anc_y;
    logic [tpgt_pkg::TIME_W-1:0]       n_elapsed;
    logic signed [tpgt_pkg::VEL_W-1:0] n_vel_x, n_vel_y;

    logic                              idx_ok;
    logic [IW-1:0]                     in_idx;
    logic [tpgt_pkg::STATE_W-1:0]      cur_state;
    logic                              cur_p;
    logic signed [2*CW+1:0]            sq_full_a, sq_full_b;
    logic signed [tpgt_pkg::TV_W-1:0]  tv_x, tv_y;
    logic                              beyond;
    logic [tpgt_pkg::STATE_W-1:0]      rep_state;
    tpgt_pkg::t_out_beat               emit_beat;

    assign idx_ok    = {1'b0, i_in_data.point_index} < NPTS_L;
    assign in_idx    = i_in_data.point_index[IW-1:0];
    assign cur_state = r_pstate[i_ptr];
    assign cur_p     = r_lat_p[i_ptr];

    assign sq_full_a = r_dx * r_dx;
    assign sq_full_b = r_dy * r_dy;
    assign tv_x = tpgt_pkg::TV_W'(r_vel_x[i_ptr]) * tpgt_pkg::VEL_GAIN
                + tpgt_pkg::TV_W'(r_vdx) * tpgt_pkg::STEP_GAIN;
    assign tv_y = tpgt_pkg::TV_W'(r_vel_y[i_ptr]) * tpgt_pkg::VEL_GAIN
                + tpgt_pkg::TV_W'(r_vdy) * tpgt_pkg::STEP_GAIN;
    assign beyond = r_d2 > tpgt_pkg::SQ_W'(r_th2);

    always_comb begin
        n_state   = cur_state;
        n_track_x = r_track_x[i_ptr];
        n_track_y = r_track_y[i_ptr];
        n_anc_x   = r_anc_x[i_ptr];
        n_anc_y   = r_anc_y[i_ptr];
        n_elapsed = r_elapsed[i_ptr];
        n_vel_x   = r_vel_x[i_ptr];
        n_vel_y   = r_vel_y[i_ptr];
        unique case (cur_state)
            tpgt_pkg::ST_NONE: begin
                if (cur_p) begin
                    n_state   = tpgt_pkg::ST_DOWN;
                    n_track_x = r_lat_x[i_ptr];
                    n_track_y = r_lat_y[i_ptr];
                    n_elapsed = '0;
                    n_vel_x   = '0;
                    n_vel_y   = '0;
                end
            end
            tpgt_pkg::ST_DOWN: begin
                if (cur_p) begin
                    n_state = tpgt_pkg::ST_HOLD;
                    n_anc_x = r_lat_x[i_ptr];
                    n_anc_y = r_lat_y[i_ptr];
                end else begin
                    n_state = tpgt_pkg::ST_NONE;
                end
            end
            tpgt_pkg::ST_UP: begin
                n_state = cur_p ? tpgt_pkg::ST_HOLD : tpgt_pkg::ST_NONE;
            end
            tpgt_pkg::ST_MSTART: begin
                if (cur_p) begin
                    n_state   = tpgt_pkg::ST_MOVE;
                    n_elapsed = r_elapsed[i_ptr] + tpgt_pkg::ELAPSED_STEP;
                end else begin
                    n_state = tpgt_pkg::ST_UP;
                end
            end
            tpgt_pkg::ST_MOVE: begin
                if (cur_p) begin
                    n_vel_x   = tpgt_pkg::sat_vel(r_tv_x);
                    n_vel_y   = tpgt_pkg::sat_vel(r_tv_y);
                    n_track_x = r_lat_x[i_ptr];
                    n_track_y = r_lat_y[i_ptr];
                    n_elapsed = r_elapsed[i_ptr] + tpgt_pkg::ELAPSED_STEP;
                end else begin
                    n_state = tpgt_pkg::ST_UP;
                end
            end
            tpgt_pkg::ST_HOLD: begin
                n_track_y = r_lat_y[i_ptr];
                if (cur_p) begin
                    n_track_x = r_lat_x[i_ptr];
                    n_elapsed = r_elapsed[i_ptr] + tpgt_pkg::ELAPSED_STEP;
                    if (beyond) begin
                        n_state = tpgt_pkg::ST_MSTART;
                    end
                end else begin
                    n_state = tpgt_pkg::ST_UP;
                end
            end
            default: begin
                n_state = tpgt_pkg::ST_NONE;
            end
        endcase
    end

    always_comb begin
        rep_state = cur_state;
        if (r_multi && (cur_state == tpgt_pkg::ST_HOLD || cur_state == tpgt_pkg::ST_MOVE)) begin
            rep_state = tpgt_pkg::ST_MULTI;
        end
        emit_beat.out_index     = tpgt_pkg::IDX_W'(i_ptr);
        emit_beat.gesture_state = rep_state;
        emit_beat.pos_x         = tpgt_pkg::COORD_W'(r_track_x[i_ptr]);
        emit_beat.pos_y         = tpgt_pkg::COORD_W'(r_track_y[i_ptr]);
        emit_beat.held_ms       = r_elapsed[i_ptr];
        emit_beat.speed_x       = r_vel_x[i_ptr];
        emit_beat.speed_y       = r_vel_y[i_ptr];
        emit_beat.last_record   = (i_ptr == r_last);
    end

    assign n_out_valid = i_cmd.emit ? 1'b1 : (i_out_stall ? r_out_valid : 1'b0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NPTS; i++) begin
                r_pstate[i]  <= tpgt_pkg::ST_NONE;
                r_track_x[i] <= '0;
                r_track_y[i] <= '0;
                r_anc_x[i]   <= '0;
                r_anc_y[i]   <= '0;
                r_elapsed[i] <= '0;
                r_vel_x[i]   <= '0;
                r_vel_y[i]   <= '0;
                r_lat_p[i]   <= 1'b0;
                r_lat_x[i]   <= '0;
                r_lat_y[i]   <= '0;
            end
            r_thr       <= tpgt_pkg::THR_RESET;
            r_any       <= 1'b0;
            r_multi     <= 1'b0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                r_any   <= 1'b0;
                r_multi <= 1'b0;
                if (idx_ok) begin
                    r_lat_p[in_idx] <= i_in_data.touch_present;
                    r_lat_x[in_idx] <= i_in_data.sample_x[CW-1:0];
                    r_lat_y[in_idx] <= i_in_data.sample_y[CW-1:0];
                end
            end
            if (i_cmd.update) begin
                r_pstate[i_ptr]  <= n_state;
                r_track_x[i_ptr] <= n_track_x;
                r_track_y[i_ptr] <= n_track_y;
                r_anc_x[i_ptr]   <= n_anc_x;
                r_anc_y[i_ptr]   <= n_anc_y;
                r_elapsed[i_ptr] <= n_elapsed;
                r_vel_x[i_ptr]   <= n_vel_x;
                r_vel_y[i_ptr]   <= n_vel_y;
                r_lat_p[i_ptr]   <= 1'b0;
                if (n_state != tpgt_pkg::ST_NONE) begin
                    r_any  <= 1'b1;
                    r_last <= i_ptr;
                    if (r_any) begin
                        r_multi <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dx  <= $signed({1'b0, r_lat_x[i_ptr]}) - $signed({1'b0, r_anc_x[i_ptr]});
            r_dy  <= $signed({1'b0, r_lat_y[i_ptr]}) - $signed({1'b0, r_anc_y[i_ptr]});
            r_vdx <= $signed({1'b0, r_lat_x[i_ptr]}) - $signed({1'b0, r_track_x[i_ptr]});
            r_vdy <= $signed({1'b0, r_lat_y[i_ptr]}) - $signed({1'b0, r_track_y[i_ptr]});
        end
        if (i_cmd.sq_a) begin
            r_sq_a <= sq_full_a[2*CW-1:0];
            r_tv_x <= tv_x;
        end
        if (i_cmd.sq_b) begin
            r_sq_b <= sq_full_b[2*CW-1:0];
            r_tv_y <= tv_y;
        end
        if (i_cmd.sum) begin
            r_d2  <= tpgt_pkg::SQ_W'(r_sq_a) + tpgt_pkg::SQ_W'(r_sq_b);
            r_th2 <= r_thr * r_thr;
        end
        if (i_cmd.emit) begin
            r_out <= emit_beat;
        end
    end

    assign o_status.point_live = (cur_state != tpgt_pkg::ST_NONE);
    assign o_status.out_free   = !r_out_valid || !i_out_stall;
    assign o_out_valid         = r_out_valid;
    assign o_out_data          = r_out;

    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> o_status.out_free)
        else $error("record emitted into a full output register");

    a_multi_implies_any: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_multi |-> r_any)
        else $error("multi flag set without an active point");

    a_update_clears_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |=> !r_lat_p[$past(i_ptr)])
        else $error("present latch survived the point update");

endmodule

`default_nettype wire

>>> rtl/tpgt_ctrl.sv
// Controller: accepts samples, walks every point through the advance pass, then the record pass.
`default_nettype none

module tpgt_ctrl #(
    parameter int NPTS = 4,
    parameter int IW   = 2
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_eot,
    input  wire tpgt_pkg::t_dp_status  i_status,
    output logic                       o_in_stall,
    output tpgt_pkg::t_dp_cmd          o_cmd,
    output logic [IW-1:0]              o_ptr
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_SQA  = 3'd2;
    localparam logic [2:0] S_SQB  = 3'd3;
    localparam logic [2:0] S_SUM  = 3'd4;
    localparam logic [2:0] S_UPD  = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    localparam logic [IW-1:0] LAST = IW'(NPTS - 1);

    logic [2:0]    r_state, n_state;
    logic [IW-1:0] r_ptr, n_ptr;
    logic          accept;
    logic          at_last;

    assign accept  = i_in_valid && (r_state == S_IDLE);
    assign at_last = (r_ptr == LAST);

    always_comb begin
        n_state = r_state;
        n_ptr   = r_ptr;
        o_cmd   = '0;
        o_cmd.accept = accept;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_in_eot) begin
                    n_state = S_LOAD;
                    n_ptr   = '0;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_SQA;
            end
            S_SQA: begin
                o_cmd.sq_a = 1'b1;
                n_state    = S_SQB;
            end
            S_SQB: begin
                o_cmd.sq_b = 1'b1;
                n_state    = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_UPD;
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                if (at_last) begin
                    n_state = S_EMIT;
                    n_ptr   = '0;
                end else begin
                    n_state = S_LOAD;
                    n_ptr   = r_ptr + IW'(1);
                end
            end
            S_EMIT: begin
                if (!i_status.point_live || i_status.out_free) begin
                    o_cmd.emit = i_status.point_live;
                    if (at_last) begin
                        n_state = S_IDLE;
                        n_ptr   = '0;
                    end else begin
                        n_ptr = r_ptr + IW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
                n_ptr   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ptr   <= '0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_ptr      = r_ptr;

    a_tick_starts_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_eot) |=> (r_state == S_LOAD && r_ptr == '0))
        else $error("end of tick did not start the advance pass at point zero");

    a_update_steps_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && !at_last) |=> (r_state == S_LOAD && r_ptr == $past(r_ptr) + IW'(1)))
        else $error("advance pass skipped or repeated a point");

    a_ptr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= LAST)
        else $error("point pointer beyond the last point");

endmodule

`default_nettype wire

>>> rtl/touch_point_gesture_tracker.sv
// Top level of the touch point gesture tracker.
// Input channel (i_in_valid / o_in_stall / i_in_data): one beat per touch point sample,
// in index order, end_of_tick set on the last sample of each 10 ms tick.
// Output channel (o_out_valid / i_out_stall / o_out_data): one record beat per active
// point after a tick, in index order, last_record set on the final one.
// Configuration: i_cfg_we writes i_cfg_data into the move distance threshold (reset 20).
// Samples without end_of_tick are accepted back to back while the controller is idle.
// A sample with end_of_tick starts an advance pass that takes each point through load,
// x square, y square, sum and update, followed by a record pass over every point in
// index order that waits at a live point while a stalled beat fills the output register.
// o_in_stall stays high through both passes. A receiver stall holds the output beat
// and halts the record pass at a live point, and a new sample is taken while the last
// record still waits.
// Reset is synchronous: every point returns to none with zeroed position, time and
// velocity, sample latches clear, the threshold goes back to 20 and no beat is valid.
`default_nettype none

module touch_point_gesture_tracker #(
    parameter int POINT_COUNT = 4,
    parameter int COORD_BITS  = 12
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire tpgt_pkg::t_in_beat          i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output tpgt_pkg::t_out_beat              o_out_data,
    input  wire logic                        i_cfg_we,
    input  wire logic [tpgt_pkg::THR_W-1:0]  i_cfg_data
);

    localparam int NPTS = (POINT_COUNT < tpgt_pkg::MAX_POINTS) ? POINT_COUNT
                                                               : tpgt_pkg::MAX_POINTS;
    localparam int CW   = (COORD_BITS < tpgt_pkg::COORD_W) ? COORD_BITS : tpgt_pkg::COORD_W;
    localparam int IW   = (NPTS > 1) ? $clog2(NPTS) : 1;

    tpgt_pkg::t_dp_cmd    cmd;
    tpgt_pkg::t_dp_status status;
    logic [IW-1:0]        ptr;

    tpgt_ctrl #(
        .NPTS (NPTS),
        .IW   (IW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_eot   (i_in_data.end_of_tick),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .o_ptr      (ptr)
    );

    tpgt_datapath #(
        .NPTS (NPTS),
        .CW   (CW),
        .IW   (IW)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_ptr       (ptr),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
